// File: rtl/uart_rb_pkg.sv
`timescale 1ns / 1ps

package uart_rb_pkg;

   // Default receive FIFO depth and the depth of the command queue.
   localparam int FIFO_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;

   // Stream widths: request data holds offset, wdata and rx_char; response
   // data holds rdata, tx_valid, tx_char, irq and error, padded to bytes.
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;

   // Register offsets.
   localparam logic [11:0] OFS_DATA = 12'h000;
   localparam logic [11:0] OFS_FLAG = 12'h018;
   localparam logic [11:0] OFS_LCR  = 12'h02c;
   localparam logic [11:0] OFS_CR   = 12'h030;
   localparam logic [11:0] OFS_IFLS = 12'h034;
   localparam logic [11:0] OFS_IMSC = 12'h038;
   localparam logic [11:0] OFS_MIS  = 12'h040;
   localparam logic [11:0] OFS_ICR  = 12'h044;

   // Status bits.
   localparam logic [15:0] FLAG_TX_EMPTY = 16'h0080;
   localparam logic [15:0] FLAG_RX_FULL  = 16'h0040;
   localparam logic [15:0] FLAG_RX_EMPTY = 16'h0010;
   localparam logic [15:0] MIS_TX        = 16'h0020;
   localparam logic [15:0] MIS_RX        = 16'h0010;
   localparam int          IMSC_TX_BIT   = 5;
   localparam int          IMSC_RX_BIT   = 4;

   // Highest legal level code.
   localparam logic [2:0] LVL_MAX = 3'd4;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RX    = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_TX_CHAR    = 3'd1,
      ERR_RX_LEVEL   = 3'd2,
      ERR_TX_LEVEL   = 3'd3,
      ERR_RX_OVERRUN = 3'd4
   } err_type;

   // What the back end has to do for one item.
   typedef enum logic [3:0] {
      CMD_NOP     = 4'd0,
      CMD_RD_DATA = 4'd1,
      CMD_RD_FLAG = 4'd2,
      CMD_RD_LCR  = 4'd3,
      CMD_RD_CR   = 4'd4,
      CMD_RD_IFLS = 4'd5,
      CMD_RD_IMSC = 4'd6,
      CMD_RD_MIS  = 4'd7,
      CMD_WR_DATA = 4'd8,
      CMD_WR_LCR  = 4'd9,
      CMD_WR_CR   = 4'd10,
      CMD_WR_IFLS = 4'd11,
      CMD_WR_IMSC = 4'd12,
      CMD_RX      = 4'd13
   } cmd_kind_type;

   // Classified item as it travels through the command queue.
   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  data;        // wdata, or the received character
      logic         tx_bad;      // write data above 127
      logic         rx_lvl_bad;  // level bits 5..3 above 4
      logic         tx_lvl_bad;  // level bits 2..0 above 4
   } cmd_type;

endpackage

// File: rtl/uart_rb_front.sv
`timescale 1ns / 1ps

module uart_rb_front
   import uart_rb_pkg::*;
(
   input  logic [1:0]  op,
   input  logic [11:0] offset,
   input  logic [15:0] wdata,
   input  logic [7:0]  rx_char,
   output cmd_type     cmd
);

   // Decode the operation and offset into one back-end command.
   always_comb begin
      cmd            = '0;
      cmd.kind       = CMD_NOP;
      cmd.data       = wdata;
      cmd.tx_bad     = (wdata[15:7] != 9'd0);
      cmd.rx_lvl_bad = (wdata[5:3] > LVL_MAX);
      cmd.tx_lvl_bad = (wdata[2:0] > LVL_MAX);
      unique case (op_type'(op))
         OP_READ: begin
            unique case (offset)
               OFS_DATA: cmd.kind = CMD_RD_DATA;
               OFS_FLAG: cmd.kind = CMD_RD_FLAG;
               OFS_LCR:  cmd.kind = CMD_RD_LCR;
               OFS_CR:   cmd.kind = CMD_RD_CR;
               OFS_IFLS: cmd.kind = CMD_RD_IFLS;
               OFS_IMSC: cmd.kind = CMD_RD_IMSC;
               OFS_MIS:  cmd.kind = CMD_RD_MIS;
               default:  cmd.kind = CMD_NOP;
            endcase
         end
         OP_WRITE: begin
            // The clear register stores a word that nothing reads back, so
            // a write to it acts like an unmapped write.
            unique case (offset)
               OFS_DATA: cmd.kind = CMD_WR_DATA;
               OFS_LCR:  cmd.kind = CMD_WR_LCR;
               OFS_CR:   cmd.kind = CMD_WR_CR;
               OFS_IFLS: cmd.kind = CMD_WR_IFLS;
               OFS_IMSC: cmd.kind = CMD_WR_IMSC;
               default:  cmd.kind = CMD_NOP;
            endcase
         end
         OP_RX: begin
            cmd.kind = CMD_RX;
            cmd.data = {8'd0, rx_char};
         end
         default: cmd.kind = CMD_NOP;
      endcase
   end

endmodule

// File: rtl/uart_rb_queue.sv
`timescale 1ns / 1ps

module uart_rb_queue
   import uart_rb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill-count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue slots carry payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/uart_rb_back.sv
`timescale 1ns / 1ps

module uart_rb_back
   import uart_rb_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [15:0] rdata,
   output logic        tx_valid,
   output logic [6:0]  tx_char,
   output logic        irq,
   output logic [2:0]  error
);

   localparam int IDX_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   // Receive FIFO storage and its pointers.
   logic [7:0]       rx_mem [FIFO_DEPTH];
   logic [7:0]       mem_q_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W:0]   tail_sum;
   logic [IDX_W-1:0] tail;

   // Software-visible registers.
   logic [7:0]  lcr_ff, lcr_in;
   logic [15:0] cr_ff, cr_in;
   logic [15:0] ifls_ff, ifls_in;
   logic [15:0] imsc_ff, imsc_in;

   // Result register.
   logic        out_valid_ff;
   logic        pop_ff;
   logic [15:0] rdata_ff, rdata_in;
   logic        txv_ff, txv_in;
   logic [6:0]  txc_ff, txc_in;
   logic        irq_ff, irq_in;
   err_type     err_ff, err_in;

   logic take, push, pop, fifo_full, fifo_empty;

   // A command is taken whenever the result register is free or drains.
   assign cmd_ready  = !out_valid_ff || out_ready;
   assign take       = cmd_valid && cmd_ready;
   assign fifo_full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign fifo_empty = (count_ff == '0);

   // Write slot is head plus count, wrapped once.
   assign tail_sum = {1'b0, count_ff} + (CNT_W + 1)'(head_ff);
   assign tail = (tail_sum >= (CNT_W + 1)'(FIFO_DEPTH))
                 ? IDX_W'(tail_sum - (CNT_W + 1)'(FIFO_DEPTH))
                 : IDX_W'(tail_sum);

   // Execute one command: state update and result fields.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      lcr_in   = lcr_ff;
      cr_in    = cr_ff;
      ifls_in  = ifls_ff;
      imsc_in  = imsc_ff;
      rdata_in = '0;
      txv_in   = 1'b0;
      txc_in   = '0;
      irq_in   = 1'b0;
      err_in   = ERR_NONE;
      push     = 1'b0;
      pop      = 1'b0;
      if (take) begin
         case (cmd.kind)
            CMD_RD_DATA: begin
               if (!fifo_empty) begin
                  pop      = 1'b1;
                  head_in  = (head_ff == IDX_W'(FIFO_DEPTH - 1)) ? '0
                             : head_ff + IDX_W'(1);
                  count_in = count_ff - CNT_W'(1);
               end
            end
            CMD_RD_FLAG: begin
               rdata_in = FLAG_TX_EMPTY | (fifo_full ? FLAG_RX_FULL : 16'd0)
                          | (fifo_empty ? FLAG_RX_EMPTY : 16'd0);
            end
            CMD_RD_LCR:  rdata_in = {8'd0, lcr_ff};
            CMD_RD_CR:   rdata_in = cr_ff;
            CMD_RD_IFLS: rdata_in = ifls_ff;
            CMD_RD_IMSC: rdata_in = imsc_ff;
            CMD_RD_MIS: begin
               rdata_in = MIS_TX | (fifo_empty ? 16'd0 : MIS_RX);
            end
            CMD_WR_DATA: begin
               if (cmd.tx_bad) begin
                  err_in = ERR_TX_CHAR;
               end else begin
                  txv_in = 1'b1;
                  txc_in = cmd.data[6:0];
               end
            end
            CMD_WR_LCR: lcr_in = cmd.data[7:0];
            CMD_WR_CR:  cr_in  = cmd.data;
            CMD_WR_IFLS: begin
               // The thresholds themselves drive nothing visible; only the
               // stored word and the error code matter.
               if (cmd.rx_lvl_bad) begin
                  err_in = ERR_RX_LEVEL;
               end else if (cmd.tx_lvl_bad) begin
                  err_in = ERR_TX_LEVEL;
               end else begin
                  ifls_in = cmd.data;
               end
            end
            CMD_WR_IMSC: begin
               imsc_in = cmd.data;
               irq_in  = cmd.data[IMSC_TX_BIT];
            end
            CMD_RX: begin
               if (fifo_full) begin
                  err_in = ERR_RX_OVERRUN;
               end else begin
                  push     = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               irq_in = imsc_ff[IMSC_RX_BIT];
            end
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         lcr_ff       <= '0;
         cr_ff        <= '0;
         ifls_ff      <= '0;
         imsc_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         lcr_ff   <= lcr_in;
         cr_ff    <= cr_in;
         ifls_ff  <= ifls_in;
         imsc_ff  <= imsc_in;
         if (take) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, loaded with each executed command.
   always_ff @(posedge clock) begin
      if (take) begin
         pop_ff   <= pop;
         rdata_ff <= rdata_in;
         txv_ff   <= txv_in;
         txc_ff   <= txc_in;
         irq_ff   <= irq_in;
         err_ff   <= err_in;
      end
   end

   // Receive FIFO memory with registered read port.
   always_ff @(posedge clock) begin
      if (push) begin
         rx_mem[tail] <= cmd.data[7:0];
      end
      if (pop) begin
         mem_q_ff <= rx_mem[head_ff];
      end
   end

   assign out_valid = out_valid_ff;
   assign rdata     = pop_ff ? {8'd0, mem_q_ff} : rdata_ff;
   assign tx_valid  = txv_ff;
   assign tx_char   = txc_ff;
   assign irq       = irq_ff;
   assign error     = err_ff;

endmodule

// File: rtl/uart_register_block.sv
// An item accepted on req_* passes through the command queue and the back
// end's result register to rsp_*; one item per cycle while rsp_* does not
// stall, with the receive FIFO memory read registered into the result.
// A two-entry command queue lets either side stall without stopping the other.
// Reset is synchronous and active high; it empties the queue and the FIFO,
// clears the software registers and result valid, not FIFO storage or payload.
`timescale 1ns / 1ps

module uart_register_block
   import uart_rb_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // offset [11:0], wdata [27:12], rx_char [35:28], zero [39:36]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // op [1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // rdata [15:0], tx_valid [16], tx_char [23:17], irq [24], error [27:25],
   // zero [31:28]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   cmd_type     front_cmd;
   cmd_type     back_cmd;
   logic        back_valid;
   logic        back_ready;
   logic [15:0] rdata;
   logic        tx_valid;
   logic [6:0]  tx_char;
   logic        irq;
   logic [2:0]  error;

   // Front end: classify the incoming item.
   uart_rb_front u_front (
      .op      (req_tuser[1:0]),
      .offset  (req_tdata[11:0]),
      .wdata   (req_tdata[27:12]),
      .rx_char (req_tdata[35:28]),
      .cmd     (front_cmd)
   );

   // Command queue between front and back.
   uart_rb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   // Back end: registers, receive FIFO and result register.
   uart_rb_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .rdata     (rdata),
      .tx_valid  (tx_valid),
      .tx_char   (tx_char),
      .irq       (irq),
      .error     (error)
   );

   assign rsp_tdata = {4'd0, error, irq, tx_char, tx_valid, rdata};

endmodule

// File: rtl/uart_rb_checker.sv
`timescale 1ns / 1ps

module uart_rb_checker
   import uart_rb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A result waiting for the sink stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // Only defined error codes appear, and the padding stays zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[27:25] <= ERR_RX_OVERRUN && rsp_tdata[31:28] == 4'd0)
      else $error("undefined error code or nonzero padding");

   // A character code only comes with a transmit, which carries no error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[16] |-> rsp_tdata[23:17] == 7'd0)
      else $error("character code without transmit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[27:25] == ERR_NONE
                                      && rsp_tdata[15:0] == 16'd0)
      else $error("transmit item with error or read data");

endmodule

bind uart_register_block uart_rb_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import uart_rb_pkg::*;

   // Run limit in clock cycles.
   localparam int CYCLE_LIMIT = 200000;

   // One response item split into its fields.
   typedef struct packed {
      logic [15:0] rdata;
      logic        tx_valid;
      logic [6:0]  tx_char;
      logic        irq;
      err_type     error;
   } uart_result_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   int n_mismatch = 0;
   int n_cycles   = 0;

   // Shadow copy of the UART state. Thresholds and the FIFO enable bit are not
   // visible at any output, so they are not tracked.
   logic [7:0]  rx_fifo [FIFO_DEPTH_DEF];
   int          rx_fill      = 0;
   int          rx_rd_ptr    = 0;
   logic [15:0] cr_word      = '0;
   logic [15:0] lcr_word     = '0;
   logic [15:0] ifls_word    = '0;
   logic [15:0] imsc_word    = '0;
   logic [15:0] icr_word     = '0;
   logic        rx_irq_on    = 1'b0;
   logic        tx_irq_on    = 1'b0;

   uart_result_t expected_rsp [$];

   uart_register_block i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Works out the response to one item and updates the shadow state.
   function automatic uart_result_t predict_response(input op_type op,
                                                     input logic [11:0] ofs,
                                                     input logic [15:0] wd,
                                                     input logic [7:0] rc);
      uart_result_t res;
      res = '{rdata: '0, tx_valid: 1'b0, tx_char: '0, irq: 1'b0, error: ERR_NONE};
      case (op)
         OP_READ: begin
            case (ofs)
               OFS_DATA: begin
                  if (rx_fill > 0) begin
                     res.rdata = {8'h00, rx_fifo[rx_rd_ptr]};
                     rx_rd_ptr = (rx_rd_ptr + 1) % FIFO_DEPTH_DEF;
                     rx_fill--;
                  end
               end
               OFS_FLAG: begin
                  res.rdata = FLAG_TX_EMPTY;
                  if (rx_fill >= FIFO_DEPTH_DEF) res.rdata |= FLAG_RX_FULL;
                  if (rx_fill == 0) res.rdata |= FLAG_RX_EMPTY;
               end
               OFS_LCR:  res.rdata = lcr_word;
               OFS_CR:   res.rdata = cr_word;
               OFS_IFLS: res.rdata = ifls_word;
               OFS_IMSC: res.rdata = imsc_word;
               OFS_MIS: begin
                  res.rdata = MIS_TX;
                  if (rx_fill > 0) res.rdata |= MIS_RX;
               end
               default: ;
            endcase
         end
         OP_WRITE: begin
            case (ofs)
               OFS_DATA: begin
                  if (wd > 16'd127) begin
                     res.error = ERR_TX_CHAR;
                  end else begin
                     res.tx_valid = 1'b1;
                     res.tx_char  = wd[6:0];
                  end
               end
               OFS_LCR: lcr_word = {8'h00, wd[7:0]};
               OFS_CR:  cr_word  = wd;
               OFS_IFLS: begin
                  // A bad receive level takes priority over a bad transmit level; either one
                  // keeps the stored word.
                  if (wd[5:3] > LVL_MAX) res.error = ERR_RX_LEVEL;
                  else if (wd[2:0] > LVL_MAX) res.error = ERR_TX_LEVEL;
                  else ifls_word = wd;
               end
               OFS_IMSC: begin
                  tx_irq_on = wd[IMSC_TX_BIT];
                  rx_irq_on = wd[IMSC_RX_BIT];
                  res.irq   = tx_irq_on;
                  imsc_word = wd;
               end
               OFS_ICR: icr_word = wd;
               default: ;
            endcase
         end
         OP_RX: begin
            if (rx_fill >= FIFO_DEPTH_DEF) begin
               res.error = ERR_RX_OVERRUN;
            end else begin
               rx_fifo[(rx_rd_ptr + rx_fill) % FIFO_DEPTH_DEF] = rc;
               rx_fill++;
            end
            res.irq = rx_irq_on;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Each accepted request item is predicted at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_rsp.push_back(predict_response(op_type'(req_tuser), req_tdata[11:0],
                                                 req_tdata[27:12], req_tdata[35:28]));
      end
   end

   // Each accepted response item is compared with the oldest prediction.
   always @(posedge clock) begin
      uart_result_t got;
      uart_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.rdata    = rsp_tdata[15:0];
         got.tx_valid = rsp_tdata[16];
         got.tx_char  = rsp_tdata[23:17];
         got.irq      = rsp_tdata[24];
         got.error    = err_type'(rsp_tdata[27:25]);
         if (expected_rsp.size() == 0) begin
            if (n_mismatch < 10)
               $display("%0t: response item with none expected: tdata=%h", $realtime,
                        rsp_tdata);
            n_mismatch++;
         end else begin
            want = expected_rsp.pop_front();
            if (got !== want) begin
               if (n_mismatch < 10)
                  $display({"%0t: mismatch: expected rdata=%h tx_valid=%b tx_char=%h ",
                            "irq=%b error=%0d, got rdata=%h tx_valid=%b tx_char=%h ",
                            "irq=%b error=%0d"}, $realtime,
                           want.rdata, want.tx_valid, want.tx_char, want.irq, want.error,
                           got.rdata, got.tx_valid, got.tx_char, got.irq, got.error);
               n_mismatch++;
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Presents one item, after a random idle gap, and returns once it is taken.
   task automatic send_item(input op_type op, input logic [11:0] ofs,
                            input logic [15:0] wd, input logic [7:0] rc);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, rc, wd, ofs};
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds the request side idle until every predicted response has arrived.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Register reads and writes at their extremes, plus the error cases.
   task automatic test_register_access();
      send_item(OP_READ,  OFS_FLAG, 16'h0000, 8'h00);
      send_item(OP_READ,  OFS_MIS,  16'h0000, 8'h00);
      send_item(OP_READ,  OFS_DATA, 16'h0000, 8'h00);
      send_item(OP_WRITE, OFS_DATA, 16'h0000, 8'h00);
      send_item(OP_WRITE, OFS_DATA, 16'd127,  8'h00);
      send_item(OP_WRITE, OFS_DATA, 16'd128,  8'h00);
      send_item(OP_WRITE, OFS_DATA, 16'hffff, 8'hff);
      send_item(OP_WRITE, OFS_LCR,  16'hffff, 8'h00);
      send_item(OP_READ,  OFS_LCR,  16'h0000, 8'h00);
      send_item(OP_WRITE, OFS_CR,   16'hffff, 8'h00);
      send_item(OP_READ,  OFS_CR,   16'h0000, 8'h00);
      // Receive level out of range, then transmit level out of range.
      send_item(OP_WRITE, OFS_IFLS, 16'h0038, 8'h00);
      send_item(OP_WRITE, OFS_IFLS, 16'h0005, 8'h00);
      send_item(OP_WRITE, OFS_IFLS, 16'hffe4, 8'h00);
      send_item(OP_READ,  OFS_IFLS, 16'h0000, 8'h00);
      // Both interrupts enabled: the write itself and each received item pulse.
      send_item(OP_WRITE, OFS_IMSC, 16'h0030, 8'h00);
      send_item(OP_RX,    12'h000,  16'h0000, 8'hff);
      send_item(OP_READ,  OFS_MIS,  16'h0000, 8'h00);
      send_item(OP_READ,  OFS_DATA, 16'h0000, 8'h00);
      send_item(OP_WRITE, OFS_ICR,  16'hffff, 8'h00);
      send_item(OP_READ,  OFS_ICR,  16'h0000, 8'h00);
      // Status registers are read-only; the unused op and unmapped offsets do nothing.
      send_item(OP_WRITE, OFS_FLAG, 16'hffff, 8'h00);
      send_item(OP_WRITE, OFS_MIS,  16'hffff, 8'h00);
      send_item(OP_NONE,  12'hfff,  16'hffff, 8'hff);
      send_item(OP_READ,  12'hfff,  16'hffff, 8'hff);
      send_item(OP_WRITE, 12'hfff,  16'h0000, 8'h00);
   endtask

   // Bursts of received characters, at most four past the FIFO depth, then draining
   // reads that may run past empty, so the pointers wrap and overrun can be hit.
   task automatic test_fifo_fill_drain(input int rounds);
      int n_push;
      int n_pop;
      for (int r = 0; r < rounds; r++) begin
         n_push = $urandom_range(FIFO_DEPTH_DEF + 4, 3);
         for (int i = 0; i < n_push; i++)
            send_item(OP_RX, 12'($urandom), 16'($urandom), 8'($urandom));
         send_item(OP_READ, OFS_FLAG, 16'h0000, 8'h00);
         n_pop = n_push + 2 - int'($urandom_range(6));
         for (int i = 0; i < n_pop; i++)
            send_item(OP_READ, OFS_DATA, 16'($urandom), 8'($urandom));
      end
   endtask

   // Picks one random item, weighted toward FIFO traffic and mapped registers.
   task automatic send_random_item();
      logic [11:0] map_ofs [8];
      int          pick;
      map_ofs = '{OFS_DATA, OFS_FLAG, OFS_LCR, OFS_CR, OFS_IFLS, OFS_IMSC, OFS_MIS, OFS_ICR};
      pick = $urandom_range(99);
      if (pick < 30)
         send_item(OP_RX, 12'($urandom), 16'($urandom), 8'($urandom));
      else if (pick < 50)
         send_item(OP_READ, OFS_DATA, 16'($urandom), 8'($urandom));
      else if (pick < 60)
         send_item(OP_WRITE, OFS_DATA,
                   $urandom_range(1) ? 16'($urandom_range(127)) : 16'($urandom),
                   8'($urandom));
      else if (pick < 85)
         send_item($urandom_range(1) ? OP_WRITE : OP_READ, map_ofs[$urandom_range(7)],
                   $urandom_range(1) ? 16'($urandom_range(63)) : 16'($urandom),
                   8'($urandom));
      else
         send_item(op_type'($urandom_range(3)), 12'($urandom), 16'($urandom),
                   8'($urandom));
   endtask

   // Random traffic with an occasional fill-and-drain burst.
   task automatic test_random_traffic(input int n_items);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 3)
            test_fifo_fill_drain(1);
         else
            send_random_item();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_register_access();
      test_fifo_fill_drain(3);
      wait_drain();

      // No idling on either side.
      test_random_traffic(70);
      wait_drain();

      // Slow sender.
      sender_idle_pct = 76;
      test_random_traffic(70);
      wait_drain();

      // Slow receiver.
      sender_idle_pct = 0;
      rsp_stall_pct   = 76;
      test_random_traffic(70);
      wait_drain();

      // Light idling on both sides.
      sender_idle_pct = 16;
      rsp_stall_pct   = 16;
      test_random_traffic(70);
      wait_drain();

      repeat (10) @(posedge clock);
      if (n_mismatch == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
